// ===== design/mi3_pkg.sv =====
package mi3_pkg;

    localparam int IW   = 16;        // element width, Q4.12
    localparam int OW   = 32;        // inverse entry width, Q16.16
    localparam int PW   = 2 * IW;    // element product
    localparam int AW   = PW + 1;    // adjugate entry
    localparam int TW   = IW + AW;   // determinant term
    localparam int DW   = TW + 1;    // determinant
    localparam int FS   = 28;        // dividend scale shift
    localparam int RW   = OW + FS;   // dividend magnitude
    localparam int QB   = OW;        // top quotient bit, flags overflow
    localparam int NDIV = QB + 1;    // divider stages, one quotient bit each
    localparam int NE   = 9;

    // adjugate entries that take the negated sub-determinant
    localparam logic [NE-1:0] ADJ_NEG = 9'b010101010;

    localparam logic [OW-1:0] Q_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] Q_MIN = {1'b1, {(OW-1){1'b0}}};

    typedef logic signed [IW-1:0] t_elem;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [AW-1:0] t_adj;
    typedef logic signed [TW-1:0] t_term;
    typedef logic signed [DW-1:0] t_det;
    typedef logic [RW-1:0]        t_rem;
    typedef logic [DW-1:0]        t_den;
    typedef logic [QB:0]          t_quo;

    typedef struct packed {
        t_elem m00;
        t_elem m01;
        t_elem m02;
        t_elem m10;
        t_elem m11;
        t_elem m12;
        t_elem m20;
        t_elem m21;
        t_elem m22;
    } t_in;

    typedef struct packed {
        logic signed [OW-1:0] inv00;
        logic signed [OW-1:0] inv01;
        logic signed [OW-1:0] inv02;
        logic signed [OW-1:0] inv10;
        logic signed [OW-1:0] inv11;
        logic signed [OW-1:0] inv12;
        logic signed [OW-1:0] inv20;
        logic signed [OW-1:0] inv21;
        logic signed [OW-1:0] inv22;
        logic                 singular;
        logic                 saturated;
    } t_out;

    typedef struct packed {
        t_rem rem;
        logic qbit;
    } t_step;

    // one restoring division step at quotient bit sh
    function automatic t_step div_step(input t_rem rem, input t_den den, input int sh);
        t_step s;
        s.qbit = ((rem >> sh) >= RW'(den));
        s.rem  = s.qbit ? (rem - (RW'(den) << sh)) : rem;
        return s;
    endfunction

endpackage

// ===== design/mi3_adj.sv =====
module mi3_adj (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mi3_pkg::t_in  i_data,
    output logic          o_valid,
    output mi3_pkg::t_adj o_adj [mi3_pkg::NE],
    output mi3_pkg::t_elem o_c0 [3]
);

    mi3_pkg::t_prod r_p [2*mi3_pkg::NE];
    mi3_pkg::t_prod n_p [2*mi3_pkg::NE];
    mi3_pkg::t_elem r_c0a [3];
    mi3_pkg::t_elem r_c0b [3];
    mi3_pkg::t_adj  r_adj [mi3_pkg::NE];
    mi3_pkg::t_adj  n_adj [mi3_pkg::NE];
    logic           r_v1;
    logic           r_v2;

    always_comb begin
        n_p[0]  = i_data.m11 * i_data.m22;  n_p[1]  = i_data.m21 * i_data.m12;
        n_p[2]  = i_data.m01 * i_data.m22;  n_p[3]  = i_data.m21 * i_data.m02;
        n_p[4]  = i_data.m01 * i_data.m12;  n_p[5]  = i_data.m11 * i_data.m02;
        n_p[6]  = i_data.m10 * i_data.m22;  n_p[7]  = i_data.m20 * i_data.m12;
        n_p[8]  = i_data.m00 * i_data.m22;  n_p[9]  = i_data.m20 * i_data.m02;
        n_p[10] = i_data.m00 * i_data.m12;  n_p[11] = i_data.m10 * i_data.m02;
        n_p[12] = i_data.m10 * i_data.m21;  n_p[13] = i_data.m20 * i_data.m11;
        n_p[14] = i_data.m00 * i_data.m21;  n_p[15] = i_data.m20 * i_data.m01;
        n_p[16] = i_data.m00 * i_data.m11;  n_p[17] = i_data.m10 * i_data.m01;
    end

    always_comb begin
        for (int k = 0; k < mi3_pkg::NE; k++) begin
            if (mi3_pkg::ADJ_NEG[k]) begin
                n_adj[k] = mi3_pkg::AW'(r_p[2*k+1]) - mi3_pkg::AW'(r_p[2*k]);
            end else begin
                n_adj[k] = mi3_pkg::AW'(r_p[2*k]) - mi3_pkg::AW'(r_p[2*k+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p      <= n_p;
            r_c0a[0] <= i_data.m00;
            r_c0a[1] <= i_data.m10;
            r_c0a[2] <= i_data.m20;
            r_c0b    <= r_c0a;
            r_adj    <= n_adj;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_adj   = r_adj;
    assign o_c0    = r_c0b;

endmodule

// ===== design/mi3_det.sv =====
module mi3_det (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  mi3_pkg::t_adj  i_adj [mi3_pkg::NE],
    input  mi3_pkg::t_elem i_c0 [3],
    output logic           o_valid,
    output mi3_pkg::t_adj  o_adj [mi3_pkg::NE],
    output mi3_pkg::t_det  o_det
);

    mi3_pkg::t_term r_t [3];
    mi3_pkg::t_adj  r_adja [mi3_pkg::NE];
    mi3_pkg::t_adj  r_adjb [mi3_pkg::NE];
    mi3_pkg::t_det  r_det;
    logic           r_v1;
    logic           r_v2;

    // expansion along the first column
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_t[k] <= mi3_pkg::TW'(i_c0[k]) * mi3_pkg::TW'(i_adj[k]);
            end
            r_adja <= i_adj;
            r_adjb <= r_adja;
            r_det  <= mi3_pkg::DW'(r_t[0]) + mi3_pkg::DW'(r_t[1]) + mi3_pkg::DW'(r_t[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    assign o_valid = r_v2;
    assign o_adj   = r_adjb;
    assign o_det   = r_det;

endmodule

// ===== design/mi3_div.sv =====
module mi3_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  mi3_pkg::t_adj             i_adj [mi3_pkg::NE],
    input  mi3_pkg::t_det             i_det,
    output logic                      o_valid,
    output mi3_pkg::t_quo             o_quo [mi3_pkg::NE],
    output logic [mi3_pkg::NE-1:0]    o_neg,
    output logic                      o_sing
);

    localparam int NS = mi3_pkg::NDIV + 1;

    mi3_pkg::t_rem          r_rem [NS][mi3_pkg::NE];
    mi3_pkg::t_quo          r_quo [NS][mi3_pkg::NE];
    mi3_pkg::t_den          r_den [NS];
    logic [mi3_pkg::NE-1:0] r_neg [NS];
    logic [NS-1:0]          r_sing;
    logic [NS-1:0]          r_v;
    mi3_pkg::t_step         n_step [mi3_pkg::NDIV][mi3_pkg::NE];
    mi3_pkg::t_den          n_den;
    logic [mi3_pkg::AW-1:0] n_mag [mi3_pkg::NE];

    always_comb begin
        n_den = i_det[mi3_pkg::DW-1] ? mi3_pkg::t_den'(-i_det) : mi3_pkg::t_den'(i_det);
        for (int k = 0; k < mi3_pkg::NE; k++) begin
            n_mag[k] = i_adj[k][mi3_pkg::AW-1] ? mi3_pkg::AW'(-i_adj[k])
                                               : mi3_pkg::AW'(i_adj[k]);
        end
    end

    // stage s settles quotient bit QB-s of every lane
    always_comb begin
        for (int s = 0; s < mi3_pkg::NDIV; s++) begin
            for (int k = 0; k < mi3_pkg::NE; k++) begin
                n_step[s][k] = mi3_pkg::div_step(r_rem[s][k], r_den[s], mi3_pkg::QB - s);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= n_den;
            r_sing[0] <= (i_det == '0);
            for (int k = 0; k < mi3_pkg::NE; k++) begin
                r_rem[0][k] <= mi3_pkg::RW'(n_mag[k]) << mi3_pkg::FS;
                r_quo[0][k] <= '0;
                r_neg[0][k] <= i_adj[k][mi3_pkg::AW-1] ^ i_det[mi3_pkg::DW-1];
            end
            for (int s = 0; s < mi3_pkg::NDIV; s++) begin
                r_den[s+1]  <= r_den[s];
                r_sing[s+1] <= r_sing[s];
                r_neg[s+1]  <= r_neg[s];
                for (int k = 0; k < mi3_pkg::NE; k++) begin
                    r_rem[s+1][k] <= n_step[s][k].rem;
                    r_quo[s+1][k] <= r_quo[s][k]
                        | (mi3_pkg::t_quo'(n_step[s][k].qbit) << (mi3_pkg::QB - s));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    assign o_valid = r_v[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_neg   = r_neg[NS-1];
    assign o_sing  = r_sing[NS-1];

endmodule

// ===== design/mi3_out.sv =====
module mi3_out (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  mi3_pkg::t_quo          i_quo [mi3_pkg::NE],
    input  logic [mi3_pkg::NE-1:0] i_neg,
    input  logic                   i_sing,
    output logic                   o_valid,
    output mi3_pkg::t_out          o_data
);

    logic [mi3_pkg::OW-1:0] n_val [mi3_pkg::NE];
    logic [mi3_pkg::NE-1:0] n_sat;
    mi3_pkg::t_out          n_data;
    mi3_pkg::t_out          r_data;
    logic                   r_valid;

    always_comb begin
        for (int k = 0; k < mi3_pkg::NE; k++) begin
            if (i_neg[k]) begin
                // magnitude of exactly 2^31 still fits as the negative bound
                n_sat[k] = i_quo[k][mi3_pkg::QB]
                         | (i_quo[k][mi3_pkg::OW-1] & (|i_quo[k][mi3_pkg::OW-2:0]));
                n_val[k] = n_sat[k] ? mi3_pkg::Q_MIN : (-i_quo[k][mi3_pkg::OW-1:0]);
            end else begin
                n_sat[k] = i_quo[k][mi3_pkg::QB] | i_quo[k][mi3_pkg::OW-1];
                n_val[k] = n_sat[k] ? mi3_pkg::Q_MAX : i_quo[k][mi3_pkg::OW-1:0];
            end
            if (i_sing) begin
                n_val[k] = '0;
            end
        end
        n_data.inv00     = n_val[0];
        n_data.inv01     = n_val[1];
        n_data.inv02     = n_val[2];
        n_data.inv10     = n_val[3];
        n_data.inv11     = n_val[4];
        n_data.inv12     = n_val[5];
        n_data.inv20     = n_val[6];
        n_data.inv21     = n_val[7];
        n_data.inv22     = n_val[8];
        n_data.singular  = i_sing;
        n_data.saturated = !i_sing && (|n_sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/matrix_inverse_3x3.sv =====
// 3x3 matrix inverse by adjugate and determinant
// input channel: i_valid / o_stall carry one word i_data, nine signed Q4.12
// elements; a word is taken at a clock edge with i_valid high and o_stall low
// output channel: o_valid / i_stall carry one word o_data, nine signed Q16.16
// inverse entries truncated toward zero and clamped, plus singular and
// saturated flags; a zero determinant gives all-zero entries and singular set
// throughput: one matrix per cycle while o_stall is low; stages from acceptance to
// o_valid: two of cofactor products, two of determinant, one operand prep stage,
// 33 restoring divider stages of one quotient bit each across nine lanes, one
// output register
// when i_stall holds a valid output word the whole pipeline freezes in place
// and o_stall rises the same cycle; words are neither lost nor repeated
// reset (i_rst_n low, synchronous) clears every stage valid bit; data
// registers are not reset
module matrix_inverse_3x3 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  mi3_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output mi3_pkg::t_out o_data
);

    logic                   en;
    logic                   adj_valid;
    mi3_pkg::t_adj          adj_adj [mi3_pkg::NE];
    mi3_pkg::t_elem         adj_c0 [3];
    logic                   det_valid;
    mi3_pkg::t_adj          det_adj [mi3_pkg::NE];
    mi3_pkg::t_det          det_det;
    logic                   div_valid;
    mi3_pkg::t_quo          div_quo [mi3_pkg::NE];
    logic [mi3_pkg::NE-1:0] div_neg;
    logic                   div_sing;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    mi3_adj u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (adj_valid),
        .o_adj   (adj_adj),
        .o_c0    (adj_c0)
    );

    mi3_det u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (adj_valid),
        .i_adj   (adj_adj),
        .i_c0    (adj_c0),
        .o_valid (det_valid),
        .o_adj   (det_adj),
        .o_det   (det_det)
    );

    mi3_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (det_valid),
        .i_adj   (det_adj),
        .i_det   (det_det),
        .o_valid (div_valid),
        .o_quo   (div_quo),
        .o_neg   (div_neg),
        .o_sing  (div_sing)
    );

    mi3_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (div_valid),
        .i_quo   (div_quo),
        .i_neg   (div_neg),
        .i_sing  (div_sing),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word waiting");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |-> (o_data.inv00 == 0 && o_data.inv11 == 0
            && o_data.inv22 == 0 && o_data.inv01 == 0 && o_data.inv12 == 0))
        else $error("singular word carries nonzero entries");

    a_singular_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.singular) |-> !o_data.saturated)
        else $error("singular word flagged saturated");

    a_hold_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (div_valid && o_stall) |=> div_valid)
        else $error("divider word dropped during stall");

endmodule

// ===== sim/matrix_inverse_3x3_test.sv =====
`timescale 1ns / 1ps

module matrix_inverse_3x3_test;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    mi3_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    mi3_pkg::t_out o_data;

    matrix_inverse_3x3 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    mi3_pkg::t_out inverse_queue[$];
    int   error_count;
    int   send_idle_pct;
    int   stall_pct;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // exact adjugate inverse, Q16.16 truncated and clamped
    function automatic mi3_pkg::t_out predict_inverse(input mi3_pkg::t_in m);
        longint a[3][3];
        longint adj[3][3];
        longint det;
        longint q;
        logic [mi3_pkg::OW-1:0] e[9];
        mi3_pkg::t_out res;
        a[0][0] = m.m00; a[0][1] = m.m01; a[0][2] = m.m02;
        a[1][0] = m.m10; a[1][1] = m.m11; a[1][2] = m.m12;
        a[2][0] = m.m20; a[2][1] = m.m21; a[2][2] = m.m22;
        adj[0][0] =   a[1][1] * a[2][2] - a[2][1] * a[1][2];
        adj[0][1] = -(a[0][1] * a[2][2] - a[2][1] * a[0][2]);
        adj[0][2] =   a[0][1] * a[1][2] - a[1][1] * a[0][2];
        adj[1][0] = -(a[1][0] * a[2][2] - a[2][0] * a[1][2]);
        adj[1][1] =   a[0][0] * a[2][2] - a[2][0] * a[0][2];
        adj[1][2] = -(a[0][0] * a[1][2] - a[1][0] * a[0][2]);
        adj[2][0] =   a[1][0] * a[2][1] - a[2][0] * a[1][1];
        adj[2][1] = -(a[0][0] * a[2][1] - a[2][0] * a[0][1]);
        adj[2][2] =   a[0][0] * a[1][1] - a[1][0] * a[0][1];
        det = a[0][0] * adj[0][0] + a[1][0] * adj[0][1] + a[2][0] * adj[0][2];
        res = '0;
        if (det == 0) begin
            res.singular = 1'b1;
            return res;
        end
        for (int k = 0; k < 9; k++) begin
            q = (adj[k / 3][k % 3] * (64'sd1 <<< 28)) / det;
            if (q > 64'sd2147483647) begin
                q = 64'sd2147483647;
                res.saturated = 1'b1;
            end else if (q < -64'sd2147483648) begin
                q = -64'sd2147483648;
                res.saturated = 1'b1;
            end
            e[k] = q[mi3_pkg::OW-1:0];
        end
        res.inv00 = e[0]; res.inv01 = e[1]; res.inv02 = e[2];
        res.inv10 = e[3]; res.inv11 = e[4]; res.inv12 = e[5];
        res.inv20 = e[6]; res.inv21 = e[7]; res.inv22 = e[8];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    task automatic send_matrix(input mi3_pkg::t_in m);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= m;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        inverse_queue.push_back(predict_inverse(m));
    endtask

    // randomize the stall line and check every accepted word
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (inverse_queue.size() == 0) begin
                    report_mismatch("unexpected word", 0, 0);
                end else begin
                    mi3_pkg::t_out w;
                    w = inverse_queue.pop_front();
                    if (o_data.inv00 !== w.inv00) report_mismatch("inv00", o_data.inv00, w.inv00);
                    if (o_data.inv01 !== w.inv01) report_mismatch("inv01", o_data.inv01, w.inv01);
                    if (o_data.inv02 !== w.inv02) report_mismatch("inv02", o_data.inv02, w.inv02);
                    if (o_data.inv10 !== w.inv10) report_mismatch("inv10", o_data.inv10, w.inv10);
                    if (o_data.inv11 !== w.inv11) report_mismatch("inv11", o_data.inv11, w.inv11);
                    if (o_data.inv12 !== w.inv12) report_mismatch("inv12", o_data.inv12, w.inv12);
                    if (o_data.inv20 !== w.inv20) report_mismatch("inv20", o_data.inv20, w.inv20);
                    if (o_data.inv21 !== w.inv21) report_mismatch("inv21", o_data.inv21, w.inv21);
                    if (o_data.inv22 !== w.inv22) report_mismatch("inv22", o_data.inv22, w.inv22);
                    if (o_data.singular !== w.singular)
                        report_mismatch("singular", o_data.singular, w.singular);
                    if (o_data.saturated !== w.saturated)
                        report_mismatch("saturated", o_data.saturated, w.saturated);
                end
            end
        end
        i_stall <= (stall_pct > 0) && ($urandom_range(99, 0) < stall_pct);
    end

    function automatic mi3_pkg::t_in rand_matrix(input int mode);
        mi3_pkg::t_in m;
        logic [mi3_pkg::IW-1:0] v[9];
        for (int k = 0; k < 9; k++) begin
            case (mode)
                0: v[k] = mi3_pkg::IW'($urandom);
                1: v[k] = mi3_pkg::IW'($urandom_range(255, 0) - 128);
                2: v[k] = $urandom_range(2, 0) == 0 ? 16'h8000 :
                          ($urandom_range(1, 0) ? 16'h7fff : 16'h0000);
                default: v[k] = mi3_pkg::IW'($urandom_range(8192, 0) - 4096);
            endcase
        end
        m = {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
        // rank-deficient: copy one row onto another
        if (mode == 4) m[47:0] = m[143:96];
        return m;
    endfunction

    task automatic test_directed();
        mi3_pkg::t_in m;
        m = '0;
        send_matrix(m);
        m.m00 = 16'sd4096; m.m11 = 16'sd4096; m.m22 = 16'sd4096;
        send_matrix(m);
        m.m00 = -16'sd4096; m.m11 = 16'sd8192; m.m22 = 16'sd2048;
        send_matrix(m);
        m = '0; m.m00 = 16'sd1; m.m11 = 16'sd1; m.m22 = 16'sd1;
        send_matrix(m);
        m = '0; m.m00 = -16'sd1; m.m11 = 16'sd1; m.m22 = 16'sd1;
        send_matrix(m);
        m = '0; m.m00 = 16'sh7fff; m.m11 = 16'sh7fff; m.m22 = 16'sh7fff;
        send_matrix(m);
        m = '0; m.m00 = 16'sh8000; m.m11 = 16'sh8000; m.m22 = 16'sh8000;
        send_matrix(m);
        m = {9{16'sh8000}};
        send_matrix(m);
        m = {9{16'sh7fff}};
        send_matrix(m);
        m = '0; m.m02 = 16'sh8000; m.m11 = 16'sh7fff; m.m20 = 16'sh8000;
        send_matrix(m);
        m = '0; m.m01 = 16'sd4096; m.m12 = 16'sd4096; m.m20 = 16'sd4096;
        send_matrix(m);
        m = {16'sh7fff, 16'sh8000, 16'sh0001, 16'sh8000, 16'sh7fff, 16'shffff,
             16'sh0001, 16'shffff, 16'sh7fff};
        send_matrix(m);
        m = {16'shffff, 16'sh5555, 16'shaaaa, 16'sh1234, 16'shedcb, 16'sh0f0f,
             16'shf0f0, 16'sh3333, 16'shcccc};
        send_matrix(m);
        for (int k = 0; k < 6; k++) send_matrix(rand_matrix(2));
    endtask

    task automatic test_random(input int count, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        for (int k = 0; k < count; k++) send_matrix(rand_matrix($urandom_range(4, 0)));
    endtask

    initial begin
        error_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400, 0, 0);
        test_random(150, 86, 0);
        test_random(300, 0, 86);
        test_random(150, 30, 30);
        test_random(200, 0, 0);
        i_valid <= 1'b0;
        stall_pct = 0;
        while (inverse_queue.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0 && inverse_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
